### hw/rtl/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV pixel converter.
// Used by the front stage, the divider cells and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rgbhsv_pkg;

	localparam int PIX_W   = 8;
	localparam int QUO_W   = 8;
	localparam int DIV_W   = 19;
	localparam int N_CELLS = QUO_W;

	typedef enum logic [1:0] {
		K6_ZERO = 2'd0,
		K6_NEG6 = 2'd1,
		K6_NEG2 = 2'd2,
		K6_POS4 = 2'd3
	} k6_sel_t;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] dvs;
		logic [QUO_W-1:0] quo;
	} div_lane_t;

	typedef struct packed {
		div_lane_t        hue;
		div_lane_t        sat;
		logic [PIX_W-1:0] bright;
	} cell_word_t;

endpackage

`default_nettype wire

### hw/rtl/rgbhsv_front.sv
// Front stages: channel sort, chroma and hue offset, then dividend and divisor setup.
// Depends on rgbhsv_pkg; feeds the first divider cell.
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [rgbhsv_pkg::PIX_W-1:0] blue,
	input  wire logic [rgbhsv_pkg::PIX_W-1:0] green,
	input  wire logic [rgbhsv_pkg::PIX_W-1:0] red,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output rgbhsv_pkg::cell_word_t        out_word
);
	import rgbhsv_pkg::*;

	logic             swap1, swap2;
	logic [PIX_W-1:0] g1, b1, r2, g2, lo;
	k6_sel_t          k6_c;

	logic             valid_s1;
	logic             ready_s1;
	logic [PIX_W-1:0] max_s1;
	logic [PIX_W-1:0] chroma_s1;
	logic signed [8:0] diff_s1;
	k6_sel_t          k6_s1;

	logic [10:0]       c6;
	logic signed [11:0] kc;
	logic [12:0]       num;
	logic [12:0]       num_abs;
	logic [10:0]       mag;
	cell_word_t        word_c;

	logic       valid_s2;
	cell_word_t word_s2;

	always_comb begin
		swap1 = green < blue;
		g1    = swap1 ? blue : green;
		b1    = swap1 ? green : blue;
		swap2 = red < g1;
		r2    = swap2 ? g1 : red;
		g2    = swap2 ? red : g1;
		lo    = (swap2 && (red < b1)) ? red : b1;
		unique case ({swap1, swap2})
			2'b00: k6_c = K6_ZERO;
			2'b10: k6_c = K6_NEG6;
			2'b01: k6_c = K6_NEG2;
			2'b11: k6_c = K6_POS4;
			default: k6_c = K6_ZERO;
		endcase
	end

	assign ready_s1 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			max_s1    <= r2;
			chroma_s1 <= r2 - lo;
			diff_s1   <= $signed({1'b0, g2}) - $signed({1'b0, b1});
			k6_s1     <= k6_c;
		end
	end

	always_comb begin
		c6 = 11'({chroma_s1, 2'b00}) + 11'({chroma_s1, 1'b0});
		unique case (k6_s1)
			K6_ZERO: kc = '0;
			K6_NEG6: kc = -$signed({1'b0, c6});
			K6_NEG2: kc = -$signed({3'b000, chroma_s1, 1'b0});
			K6_POS4: kc = $signed({2'b00, chroma_s1, 2'b00});
			default: kc = '0;
		endcase
		num     = {kc[11], kc} + {{4{diff_s1[8]}}, diff_s1};
		num_abs = num[12] ? (13'd0 - num) : num;
		mag     = num_abs[10:0];

		word_c.hue.rem = {mag, 8'b0} - {8'b0, mag};
		word_c.hue.dvs = (chroma_s1 == '0) ? (DIV_W'(1) << (QUO_W - 1)) : {1'b0, c6, 7'b0};
		word_c.hue.quo = '0;
		word_c.sat.rem = {3'b000, ({chroma_s1, 8'b0} - {8'b0, chroma_s1})};
		word_c.sat.dvs = (max_s1 == '0) ? (DIV_W'(1) << (QUO_W - 1)) :
			{4'b0000, max_s1, 7'b0};
		word_c.sat.quo = '0;
		word_c.bright  = max_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			word_s2 <= word_c;
		end
	end

	assign out_valid = valid_s2;
	assign out_word  = word_s2;

endmodule

`default_nettype wire

### hw/rtl/rgbhsv_cell.sv
// One restoring-division cell: one quotient bit for the hue and saturation lanes.
// Depends on rgbhsv_pkg; chained by the top level.
`timescale 1ns / 1ps
`default_nettype none

module rgbhsv_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire rgbhsv_pkg::cell_word_t in_word,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output rgbhsv_pkg::cell_word_t out_word
);
	import rgbhsv_pkg::*;

	function automatic div_lane_t div_step(div_lane_t l);
		div_lane_t n;
		logic      ge;
		ge    = l.rem >= l.dvs;
		n.rem = ge ? (l.rem - l.dvs) : l.rem;
		n.dvs = l.dvs >> 1;
		n.quo = {l.quo[QUO_W-2:0], ge};
		return n;
	endfunction

	logic       valid_q;
	cell_word_t word_q;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_q.hue    <= div_step(in_word.hue);
			word_q.sat    <= div_step(in_word.sat);
			word_q.bright <= in_word.bright;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

`default_nettype wire

### hw/rtl/rgb_to_hsv_pixel.sv
// Top level of the RGB to HSV pixel converter: front stages and a chain of divider cells.
// Depends on rgbhsv_pkg, rgbhsv_front and rgbhsv_cell.
//
// Usage:
//   Slave channel s_t* takes one pixel word: blue, green, red bytes.
//   Master channel m_t* returns one word per pixel: hue, saturation, brightness.
//   A word is accepted when tvalid and tready are both high.
//   The pipeline has two front stages (sort, then dividend setup) and
//   eight division cells, each resolving one quotient bit of both the hue
//   and saturation quotients. The last cell is the output register.
//   Throughput is one pixel per cycle while m_tready is high; every stage holds
//   its own valid bit, so bubbles collapse and a new pixel enters while results wait.
//   When m_tready is low, the stages fill up behind the held output word and
//   s_tready drops once the whole chain is occupied.
//   Reset clears all valid bits; no word is in flight afterwards.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_pixel (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // blue[7:0], green[15:8], red[23:16]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // hue[7:0], saturation[15:8], brightness[23:16]
);
	import rgbhsv_pkg::*;

	logic       link_valid [0:N_CELLS];
	logic       link_ready [0:N_CELLS];
	cell_word_t link_word  [0:N_CELLS];

	rgbhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.blue      (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.red       (s_tdata[23:16]),
		.out_valid (link_valid[0]),
		.out_ready (link_ready[0]),
		.out_word  (link_word[0])
	);

	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		rgbhsv_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[i]),
			.in_ready  (link_ready[i]),
			.in_word   (link_word[i]),
			.out_valid (link_valid[i+1]),
			.out_ready (link_ready[i+1]),
			.out_word  (link_word[i+1])
		);
	end

	assign link_ready[N_CELLS] = m_tready;
	assign m_tvalid = link_valid[N_CELLS];
	assign m_tdata  = {link_word[N_CELLS].bright,
	                   link_word[N_CELLS].sat.quo,
	                   link_word[N_CELLS].hue.quo};

endmodule

`default_nettype wire
